// ===== hw/rtl/ac3sfh_pkg.sv =====
// ----------------------------------------------------------------------------
// ac3sfh_pkg
// Shared constants and the A/52 frame size table for the AC-3 sync frame
// header scanner.
// ----------------------------------------------------------------------------
package ac3sfh_pkg;

   localparam int OFFSET_BITS = 40;
   localparam int SKIP_BITS   = 12;
   localparam int WORDS_BITS  = 11;

   localparam logic [7:0] SYNC_HI  = 8'h0B;
   localparam logic [7:0] SYNC_LO  = 8'h77;

   // Header bytes after the sync word; the last one is taken straight off
   // the input and never stored.
   localparam int HDR_BYTES = 6;
   localparam int HDR_STORE = HDR_BYTES - 1;
   localparam logic [2:0] HDR_LAST = 3'(HDR_BYTES - 1);

   localparam logic [1:0] RATE_48K      = 2'd0;
   localparam logic [1:0] RATE_44K      = 2'd1;
   localparam logic [1:0] RATE_32K      = 2'd2;
   localparam logic [1:0] RATE_RESERVED = 2'd3;
   localparam logic [5:0] SIZE_LIMIT    = 6'd38;

   localparam logic [2:0] ACMOD_1_0   = 3'd1;
   localparam logic [2:0] ACMOD_2_0   = 3'd2;

   // Bytes of the frame already consumed when the header is decoded.
   localparam logic [SKIP_BITS-1:0] HDR_FRAME_BYTES = SKIP_BITS'(8);

   typedef logic [WORDS_BITS-1:0] words_type;

   localparam words_type TBL_48K [38] = '{
      11'd64,   11'd64,   11'd80,   11'd80,   11'd96,   11'd96,   11'd112,  11'd112,
      11'd128,  11'd128,  11'd160,  11'd160,  11'd192,  11'd192,  11'd224,  11'd224,
      11'd256,  11'd256,  11'd320,  11'd320,  11'd384,  11'd384,  11'd448,  11'd448,
      11'd512,  11'd512,  11'd640,  11'd640,  11'd768,  11'd768,  11'd896,  11'd896,
      11'd1024, 11'd1024, 11'd1152, 11'd1152, 11'd1280, 11'd1280
   };

   localparam words_type TBL_44K [38] = '{
      11'd69,   11'd70,   11'd87,   11'd88,   11'd104,  11'd105,  11'd121,  11'd122,
      11'd139,  11'd140,  11'd174,  11'd175,  11'd208,  11'd209,  11'd243,  11'd244,
      11'd278,  11'd279,  11'd348,  11'd349,  11'd417,  11'd418,  11'd487,  11'd488,
      11'd557,  11'd558,  11'd696,  11'd697,  11'd835,  11'd836,  11'd975,  11'd976,
      11'd1114, 11'd1115, 11'd1253, 11'd1254, 11'd1393, 11'd1394
   };

   localparam words_type TBL_32K [38] = '{
      11'd96,   11'd96,   11'd120,  11'd120,  11'd144,  11'd144,  11'd168,  11'd168,
      11'd192,  11'd192,  11'd240,  11'd240,  11'd288,  11'd288,  11'd336,  11'd336,
      11'd384,  11'd384,  11'd480,  11'd480,  11'd576,  11'd576,  11'd672,  11'd672,
      11'd768,  11'd768,  11'd960,  11'd960,  11'd1152, 11'd1152, 11'd1344, 11'd1344,
      11'd1536, 11'd1536, 11'd1728, 11'd1728, 11'd1920, 11'd1920
   };

   // Frame length in 16-bit words; zero for reserved codes.
   function automatic words_type frame_words(input logic [1:0] rate, input logic [5:0] size);
      words_type w;
      w = '0;
      if (size < SIZE_LIMIT) begin
         case (rate)
            RATE_48K: w = TBL_48K[size];
            RATE_44K: w = TBL_44K[size];
            RATE_32K: w = TBL_32K[size];
            default:  w = '0;
         endcase
      end
      return w;
   endfunction

endpackage

// ===== hw/rtl/ac3_sync_frame_header_scanner.sv =====
// ----------------------------------------------------------------------------
// ac3_sync_frame_header_scanner
// Scans an AC-3 byte stream for sync frames and reports each frame header.
// ----------------------------------------------------------------------------
// One stream byte per cycle while the decode stage is not held:
// a byte lands in an input register, is decoded against the scanner state in
// the next cycle, and unless that stage is held a header result is written to
// the output register at the end of that cycle. A result is emitted on the
// sixth byte after each 0x0B77 sync word; while a result waits on rsp_ready
// the scanner keeps taking bytes and only holds when another header completes.
// csr_wr_data sets how many leading bytes are ignored before hunting begins
// and takes effect only before that skip has ended. Frames with reserved
// rate or size codes report header_valid low and frame_words zero, and
// hunting resumes right after the header.
// ----------------------------------------------------------------------------
module ac3_sync_frame_header_scanner
   import ac3sfh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OFFSET_BITS-1:0] rsp_sync_offset,
   output logic [15:0]            rsp_crc_word,
   output logic [1:0]             rsp_rate_code,
   output logic [5:0]             rsp_size_code,
   output logic [10:0]            rsp_frame_words,
   output logic [4:0]             rsp_stream_id,
   output logic [2:0]             rsp_service_mode,
   output logic [2:0]             rsp_channel_mode,
   output logic                   rsp_lfe_present,
   output logic                   rsp_header_valid
);

   typedef enum logic [1:0] {
      PH_START,
      PH_HUNT,
      PH_HEADER,
      PH_SKIP
   } phase_type;

   // control and state registers
   phase_type              phase_ff, phase_in;
   logic [31:0]            start_skip_ff;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                   prev_sync_ff, prev_sync_in;
   logic [2:0]             hdr_count_ff, hdr_count_in;
   logic [7:0]             hdr_ff [HDR_STORE];
   logic [SKIP_BITS-1:0]   skip_ff, skip_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic [7:0]             s1_byte_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   // result register
   logic [OFFSET_BITS-1:0] sync_offset_ff;
   logic [15:0]            crc_word_ff;
   logic [1:0]             rate_code_ff;
   logic [5:0]             size_code_ff;
   words_type              frame_words_ff;
   logic [4:0]             stream_id_ff;
   logic [2:0]             service_mode_ff;
   logic [2:0]             channel_mode_ff;
   logic                   lfe_present_ff;
   logic                   header_valid_ff;

   logic       req_accept;
   logic       s1_go;
   logic       emit;
   logic       hdr_store;
   phase_type  eff_phase;

   // decoded header fields
   logic [1:0]           dec_rate;
   logic [5:0]           dec_size;
   logic [2:0]           dec_acmod;
   logic                 dec_valid;
   words_type            dec_words;
   logic [1:0]           mix_fields;
   logic                 dec_lfe;
   logic [SKIP_BITS-1:0] dec_skip;

   // ---------------------------------------------------------------------
   // header decode, last header byte straight from the input register
   // ---------------------------------------------------------------------
   always_comb begin
      dec_rate  = hdr_ff[2][7:6];
      dec_size  = hdr_ff[2][5:0];
      dec_acmod = hdr_ff[4][7:5];
      dec_valid = (dec_rate != RATE_RESERVED) && (dec_size < SIZE_LIMIT);
      dec_words = frame_words(dec_rate, dec_size);
      dec_skip  = {dec_words, 1'b0} - HDR_FRAME_BYTES;

      // count optional 2-bit mix fields ahead of lfeon
      mix_fields = 2'(dec_acmod[0] && (dec_acmod != ACMOD_1_0))
                 + 2'(dec_acmod[2])
                 + 2'(dec_acmod == ACMOD_2_0);
      case (mix_fields)
         2'd0:    dec_lfe = hdr_ff[4][4];
         2'd1:    dec_lfe = hdr_ff[4][2];
         2'd2:    dec_lfe = hdr_ff[4][0];
         default: dec_lfe = s1_byte_ff[6];
      endcase
   end

   // ---------------------------------------------------------------------
   // scanner control
   // ---------------------------------------------------------------------
   always_comb begin
      if (phase_ff == PH_START && pos_ff >= {{(OFFSET_BITS-32){1'b0}}, start_skip_ff}) begin
         eff_phase = PH_HUNT;
      end else begin
         eff_phase = phase_ff;
      end

      emit      = s1_valid_ff && (eff_phase == PH_HEADER) && (hdr_count_ff == HDR_LAST);
      // hold the decode stage only when a second header would overwrite a waiting one
      s1_go     = s1_valid_ff && !(emit && rsp_valid_ff && !rsp_ready);
      req_ready = !s1_valid_ff || s1_go;
      req_accept = req_valid && req_ready;

      s1_valid_in  = req_accept || (s1_valid_ff && !s1_go);
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);

      phase_in     = phase_ff;
      pos_in       = pos_ff;
      prev_sync_in = prev_sync_ff;
      hdr_count_in = hdr_count_ff;
      skip_in      = skip_ff;
      hdr_store    = 1'b0;

      if (s1_go) begin
         pos_in = pos_ff + OFFSET_BITS'(1);
         unique case (eff_phase)
            PH_START: begin
               phase_in = PH_START;
            end
            PH_HUNT: begin
               phase_in     = PH_HUNT;
               prev_sync_in = (s1_byte_ff == SYNC_HI);
               if (prev_sync_ff && s1_byte_ff == SYNC_LO) begin
                  phase_in     = PH_HEADER;
                  hdr_count_in = '0;
               end
            end
            PH_HEADER: begin
               if (hdr_count_ff == HDR_LAST) begin
                  hdr_count_in = '0;
                  if (dec_valid) begin
                     phase_in = PH_SKIP;
                     skip_in  = dec_skip;
                  end else begin
                     phase_in     = PH_HUNT;
                     prev_sync_in = 1'b0;
                  end
               end else begin
                  hdr_store    = 1'b1;
                  hdr_count_in = hdr_count_ff + 3'd1;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - SKIP_BITS'(1);
               if (skip_ff == SKIP_BITS'(1)) begin
                  phase_in     = PH_HUNT;
                  prev_sync_in = 1'b0;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         start_skip_ff <= '0;
         pos_ff        <= '0;
         prev_sync_ff  <= 1'b0;
         hdr_count_ff  <= '0;
         skip_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         prev_sync_ff <= prev_sync_in;
         hdr_count_ff <= hdr_count_in;
         skip_ff      <= skip_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            start_skip_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_data_byte;
      end
      if (hdr_store) begin
         hdr_ff[hdr_count_ff] <= s1_byte_ff;
      end
      if (emit && s1_go) begin
         sync_offset_ff  <= pos_ff - OFFSET_BITS'(7);
         crc_word_ff     <= {hdr_ff[0], hdr_ff[1]};
         rate_code_ff    <= dec_rate;
         size_code_ff    <= dec_size;
         frame_words_ff  <= dec_words;
         stream_id_ff    <= hdr_ff[3][7:3];
         service_mode_ff <= hdr_ff[3][2:0];
         channel_mode_ff <= dec_acmod;
         lfe_present_ff  <= dec_lfe;
         header_valid_ff <= dec_valid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sync_offset  = sync_offset_ff;
   assign rsp_crc_word     = crc_word_ff;
   assign rsp_rate_code    = rate_code_ff;
   assign rsp_size_code    = size_code_ff;
   assign rsp_frame_words  = frame_words_ff;
   assign rsp_stream_id    = stream_id_ff;
   assign rsp_service_mode = service_mode_ff;
   assign rsp_channel_mode = channel_mode_ff;
   assign rsp_lfe_present  = lfe_present_ff;
   assign rsp_header_valid = header_valid_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_hdr_count_range: assert property (@(posedge clock) disable iff (reset)
      hdr_count_ff <= HDR_LAST)
      else $error("header byte count out of range");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != '0)
      else $error("frame skip phase with zero bytes left");

   a_result_from_header: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(phase_ff) == PH_HEADER && $past(hdr_count_ff) == HDR_LAST)
      else $error("result raised outside a header completion");

   a_words_match_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_header_valid == (rsp_frame_words != '0)))
      else $error("frame length disagrees with header valid flag");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && s1_valid_ff && emit |=> $stable(sync_offset_ff))
      else $error("waiting result overwritten");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the AC-3 sync frame header scanner. A byte driver
// with bursty timing feeds sync words, headers, frame bodies and noise; a
// header predictor tracks the scanner state for every accepted byte, and the
// monitor compares every reported header field by field against it.
// ----------------------------------------------------------------------------
module testbench
   import ac3sfh_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {SCAN_START, SCAN_HUNT, SCAN_HEADER, SCAN_SKIP} scan_phase_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] sync_offset;
      logic [15:0]            crc_word;
      logic [1:0]             rate_code;
      logic [5:0]             size_code;
      logic [10:0]            frame_words;
      logic [4:0]             stream_id;
      logic [2:0]             service_mode;
      logic [2:0]             channel_mode;
      logic                   lfe_present;
      logic                   header_valid;
   } frame_header_type;

   localparam logic [7:0] RATE_MASK     = 8'hC0;
   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_CAP    = 100;

   // Frame words at 48 kHz per pair of size codes; 32 kHz is 3/2 of it.
   localparam int BASE_WORDS [19] = '{
      64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 448, 512, 640, 768, 896,
      1024, 1152, 1280
   };
   // 44.1 kHz, even size codes; odd codes carry one more word.
   localparam int WORDS_44K [19] = '{
      69, 87, 104, 121, 139, 174, 208, 243, 278, 348, 417, 487, 557, 696, 835, 975,
      1114, 1253, 1393
   };

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   csr_wr_en     = 1'b0;
   logic [31:0]            csr_wr_data   = '0;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic [OFFSET_BITS-1:0] rsp_sync_offset;
   logic [15:0]            rsp_crc_word;
   logic [1:0]             rsp_rate_code;
   logic [5:0]             rsp_size_code;
   logic [10:0]            rsp_frame_words;
   logic [4:0]             rsp_stream_id;
   logic [2:0]             rsp_service_mode;
   logic [2:0]             rsp_channel_mode;
   logic                   rsp_lfe_present;
   logic                   rsp_header_valid;

   // scanner state as predicted
   logic [31:0]            lead_skip  = '0;
   logic [OFFSET_BITS-1:0] scan_pos   = '0;
   scan_phase_type         scan_phase = SCAN_START;
   logic [7:0]             scan_prev  = '0;
   logic [2:0]             hdr_cnt    = '0;
   logic [7:0]             hdr_buf [HDR_BYTES];
   logic [31:0]            frame_left = '0;

   logic [7:0]       byte_q [$];
   frame_header_type header_q [$];

   int   errors          = 0;
   int   idle_cycles     = 0;
   int   counted_items   = 0;
   int   planned_headers = 0;
   logic req_taken       = 1'b0;
   int   burst_left      = 0;
   int   gap_left        = 0;
   int   hold_left       = 0;
   int   rcv_cycle       = 0;
   bit   long_hold_go    = 1'b0;
   bit   long_hold_done  = 1'b0;

   ac3_sync_frame_header_scanner uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sync_offset  (rsp_sync_offset),
      .rsp_crc_word     (rsp_crc_word),
      .rsp_rate_code    (rsp_rate_code),
      .rsp_size_code    (rsp_size_code),
      .rsp_frame_words  (rsp_frame_words),
      .rsp_stream_id    (rsp_stream_id),
      .rsp_service_mode (rsp_service_mode),
      .rsp_channel_mode (rsp_channel_mode),
      .rsp_lfe_present  (rsp_lfe_present),
      .rsp_header_valid (rsp_header_valid)
   );

   always #1 clock = ~clock;

   function automatic logic [10:0] frame_len(input logic [1:0] rate, input logic [5:0] size);
      int base;
      base = BASE_WORDS[size[5:1]];
      case (rate)
         RATE_44K: return 11'(WORDS_44K[size[5:1]] + int'(size[0]));
         RATE_32K: return 11'(base * 3 / 2);
         default:  return 11'(base);
      endcase
   endfunction

   // Advance the scanner by one byte; return 1 when a header completes.
   function automatic bit scan_byte(input logic [7:0] b, output frame_header_type hdr);
      logic [1:0]  rate;
      logic [5:0]  size;
      logic [2:0]  acmod;
      logic [15:0] tail;
      logic [10:0] words;
      logic [3:0]  used;
      bit          ok;
      bit          emitted;
      emitted = 1'b0;
      hdr = '0;
      if (scan_phase == SCAN_START && scan_pos >= lead_skip) begin
         scan_phase = SCAN_HUNT;
         scan_prev  = '0;
      end
      case (scan_phase)
         SCAN_HUNT: begin
            if (scan_prev == SYNC_HI && b == SYNC_LO) begin
               scan_phase = SCAN_HEADER;
               hdr_cnt    = '0;
            end
            scan_prev = b;
         end
         SCAN_HEADER: begin
            hdr_buf[hdr_cnt] = b;
            hdr_cnt++;
            if (hdr_cnt == HDR_BYTES) begin
               hdr_cnt = '0;
               rate  = hdr_buf[2][7:6];
               size  = hdr_buf[2][5:0];
               acmod = hdr_buf[4][7:5];
               tail  = {hdr_buf[4], hdr_buf[5]};
               ok    = rate != RATE_RESERVED && size < SIZE_LIMIT;
               words = ok ? frame_len(rate, size) : '0;
               // lfeon sits behind the optional mix level fields
               used = 4'd3;
               if (acmod[0] && acmod != ACMOD_1_0) used += 4'd2;
               if (acmod[2]) used += 4'd2;
               if (acmod == ACMOD_2_0) used += 4'd2;
               hdr.sync_offset  = scan_pos - 7;
               hdr.crc_word     = {hdr_buf[0], hdr_buf[1]};
               hdr.rate_code    = rate;
               hdr.size_code    = size;
               hdr.frame_words  = words;
               hdr.stream_id    = hdr_buf[3][7:3];
               hdr.service_mode = hdr_buf[3][2:0];
               hdr.channel_mode = acmod;
               hdr.lfe_present  = tail[4'd15 - used];
               hdr.header_valid = ok;
               frame_left = ok ? 32'(words) * 2 - 8 : '0;
               if (frame_left != 0) begin
                  scan_phase = SCAN_SKIP;
               end else begin
                  scan_phase = SCAN_HUNT;
                  scan_prev  = '0;
               end
               emitted = 1'b1;
            end
         end
         SCAN_SKIP: begin
            if (frame_left > 0) frame_left--;
            if (frame_left == 0) begin
               scan_phase = SCAN_HUNT;
               scan_prev  = '0;
            end
         end
         default: ;
      endcase
      scan_pos = scan_pos + 1;
      return emitted;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      if (errors <= PRINT_CAP)
         $display("%0t ns mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
   endtask

   // Byte driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0 || byte_q.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            req_valid     <= 1'b1;
            req_data_byte <= byte_q.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 48);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // Result receiver: rotate through stall patterns, with one long hold-off.
   always @(negedge clock) begin
      rcv_cycle++;
      if (long_hold_go && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case ((rcv_cycle / 128) % 4)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= $urandom_range(0, 3) != 0;
            2:       rsp_ready <= (rcv_cycle % 7) < 3;
            default: rsp_ready <= $urandom_range(0, 1);
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      frame_header_type want;
      frame_header_type hdr;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (header_q.size() == 0) begin
               report_mismatch("header with none pending", rsp_sync_offset, 0);
            end else begin
               want = header_q.pop_front();
               if (rsp_sync_offset !== want.sync_offset)
                  report_mismatch("sync_offset", rsp_sync_offset, want.sync_offset);
               if (rsp_crc_word !== want.crc_word)
                  report_mismatch("crc_word", rsp_crc_word, want.crc_word);
               if (rsp_rate_code !== want.rate_code)
                  report_mismatch("rate_code", rsp_rate_code, want.rate_code);
               if (rsp_size_code !== want.size_code)
                  report_mismatch("size_code", rsp_size_code, want.size_code);
               if (rsp_frame_words !== want.frame_words)
                  report_mismatch("frame_words", rsp_frame_words, want.frame_words);
               if (rsp_stream_id !== want.stream_id)
                  report_mismatch("stream_id", rsp_stream_id, want.stream_id);
               if (rsp_service_mode !== want.service_mode)
                  report_mismatch("service_mode", rsp_service_mode, want.service_mode);
               if (rsp_channel_mode !== want.channel_mode)
                  report_mismatch("channel_mode", rsp_channel_mode, want.channel_mode);
               if (rsp_lfe_present !== want.lfe_present)
                  report_mismatch("lfe_present", rsp_lfe_present, want.lfe_present);
               if (rsp_header_valid !== want.header_valid)
                  report_mismatch("header_valid", rsp_header_valid, want.header_valid);
            end
         end
         if (req_valid && req_ready) begin
            if (scan_byte(req_data_byte, hdr)) header_q.push_back(hdr);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      byte_q.push_back(b);
      counted_items++;
   endtask

   // Sync word, six header bytes (first byte in the top octet), frame body.
   task automatic push_frame(input logic [47:0] hdr, input int body_len, input bit tail_hi);
      int start;
      int k;
      push_byte(SYNC_HI);
      push_byte(SYNC_LO);
      for (int i = HDR_BYTES - 1; i >= 0; i--) push_byte(hdr[8*i +: 8]);
      planned_headers++;
      start = byte_q.size();
      repeat (body_len) push_byte(8'($urandom));
      // plant a false sync inside some bodies
      if (body_len >= 2 && $urandom_range(0, 3) == 0) begin
         k = start + $urandom_range(0, body_len - 2);
         byte_q[k]     = SYNC_HI;
         byte_q[k + 1] = SYNC_LO;
      end
      if (tail_hi && body_len > 0) byte_q[byte_q.size() - 1] = SYNC_HI;
   endtask

   task automatic stream_frames(input int item_goal, input int header_goal);
      logic [7:0]  hb2;
      logic [47:0] hdr;
      int          pick;
      while (counted_items < item_goal || planned_headers < header_goal) begin
         pick = $urandom_range(0, 9);
         repeat ($urandom_range(0, 3))
            push_byte(($urandom_range(0, 3) == 0) ? SYNC_HI : 8'($urandom));
         hdr = {16'($urandom), 32'($urandom)};
         if (pick < 4) begin
            // mostly the shortest frames, now and then a mid size
            hb2 = {2'($urandom_range(0, 2)),
                   ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 11))
                                               : 6'($urandom_range(0, 3))};
            hdr[31:24] = hb2;
            push_frame(hdr, 2 * int'(frame_len(hb2[7:6], hb2[5:0])) - 8,
                       $urandom_range(0, 1));
         end else if (pick < 9) begin
            hb2 = 8'($urandom);
            while (hb2[7:6] != RATE_RESERVED && hb2[5:0] < SIZE_LIMIT) hb2 = 8'($urandom);
            hdr[31:24] = hb2;
            push_frame(hdr, 0, 1'b0);
         end else begin
            // broken sync: high byte without its partner
            push_byte(SYNC_HI);
            push_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, SYNC_LO - 1))
                                                  : 8'($urandom_range(SYNC_LO + 1, 255)));
         end
      end
   endtask

   task automatic write_lead_skip(input logic [31:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      lead_skip    = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Hold off until the queue is drained and every header has come back.
   task automatic settle();
      while (byte_q.size() != 0 || req_valid || header_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_lead_skip(32'd1);

      // sync split across the lead skip must not be found
      push_byte(SYNC_HI);
      push_byte(SYNC_LO);
      push_frame(48'hFFFF_FFFF_FFFF, 0, 1'b0);
      push_frame(48'h0000_0000_0000, 2 * int'(frame_len(RATE_48K, 6'd0)) - 8, 1'b1);
      // sync split across the frame end must not be found either
      push_byte(SYNC_LO);
      push_frame({8'h12, 8'h34, 8'hA6, 8'h5D, 8'h5F, 8'h00}, 0, 1'b0);
      settle();

      // late writes: no effect once hunting has begun
      write_lead_skip('1);
      long_hold_go = 1'b1;
      repeat (12) push_frame({16'($urandom), RATE_MASK | 8'($urandom), 24'($urandom)}, 0, 1'b0);
      stream_frames(575, 20);
      settle();

      write_lead_skip('0);
      push_frame({16'($urandom), {RATE_44K, 6'd1}, 24'($urandom)},
                 2 * int'(frame_len(RATE_44K, 6'd1)) - 8, 1'b0);
      stream_frames(1150, 26);
      settle();

      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ac3sfh_pkg.sv
hw/rtl/ac3_sync_frame_header_scanner.sv
dv/testbench.sv
